/* hdl/pemf_pkg.sv */
// ----------------------------------------------------------------------------
// pemf_pkg
// Types and constants shared by the PDF end marker finder.
// ----------------------------------------------------------------------------
package pemf_pkg;

    localparam logic [31:0] WINDOW_DEFAULT = 32'd1048576;

    localparam logic [71:0] XREF_PAT = "startxref";
    localparam logic [39:0] EOF_PAT  = "%%EOF";
    localparam logic [7:0]  CHAR_CR  = 8'h0D;
    localparam logic [7:0]  CHAR_LF  = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       lookahead;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [31:0] end_offset;
    } t_out_word;

    typedef struct packed {
        logic       advance;
        logic [7:0] data_byte;
        logic       lookahead;
        logic       last;
    } t_step;

    typedef struct packed {
        logic xref_hit;
        logic eof_hit;
    } t_match;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_AFTER_CR
    } t_eol_phase;

endpackage

/* hdl/pemf_matcher.sv */
// ----------------------------------------------------------------------------
// pemf_matcher
// Holds the last nine region bytes and flags marker completions.
// ----------------------------------------------------------------------------
module pemf_matcher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pemf_pkg::t_step i_step,
    output pemf_pkg::t_match o_match
);

    logic [71:0] r_recent;
    logic [71:0] n_recent;
    logic [71:0] w_window;

    assign w_window = {r_recent[63:0], i_step.data_byte};

    always_comb begin
        o_match.xref_hit = !i_step.lookahead && (w_window == pemf_pkg::XREF_PAT);
        o_match.eof_hit  = !i_step.lookahead && (w_window[39:0] == pemf_pkg::EOF_PAT);
    end

    always_comb begin
        n_recent = r_recent;
        if (i_step.advance) begin
            if (i_step.last || i_step.lookahead) begin
                n_recent = '0;
            end else begin
                n_recent = w_window;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
        end else begin
            r_recent <= n_recent;
        end
    end

endmodule

/* hdl/pemf_tracker.sv */
// ----------------------------------------------------------------------------
// pemf_tracker
// Tracks marker positions and line-end extension, and forms the result.
// ----------------------------------------------------------------------------
module pemf_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pemf_pkg::t_step     i_step,
    input  pemf_pkg::t_match    i_match,
    input  logic [31:0]         i_window,
    output pemf_pkg::t_out_word o_result
);

    logic [31:0] r_pos, n_pos;
    logic        r_xref_seen, n_xref_seen;
    logic [31:0] r_xref_end, n_xref_end;
    logic        r_first_seen, n_first_seen;
    logic [31:0] r_first_end, n_first_end;
    logic        r_last_seen, n_last_seen;
    logic [31:0] r_last_end, n_last_end;
    logic [1:0]  r_first_skip, n_first_skip;
    logic [1:0]  r_last_skip, n_last_skip;
    pemf_pkg::t_eol_phase r_phase, n_phase;

    logic [32:0] w_end;
    logic [32:0] w_limit;
    logic        w_eof_first;
    logic        w_eof_win;
    logic        w_skip_set;
    logic [1:0]  w_skip_val;
    logic [31:0] w_sel_end;
    logic [1:0]  w_sel_skip;

    assign w_end   = {1'b0, r_pos} + 33'd1;
    assign w_limit = {1'b0, r_xref_end} + {1'b0, i_window};

    assign w_eof_first = i_match.eof_hit && !r_xref_seen && !r_first_seen;
    assign w_eof_win   = i_match.eof_hit && r_xref_seen
                         && ((w_end - 33'd5) >= {1'b0, r_xref_end})
                         && (w_end <= w_limit);

    always_comb begin
        n_phase = pemf_pkg::PH_IDLE;
        unique case (r_phase)
            pemf_pkg::PH_FIRST: begin
                if (!i_step.lookahead && (i_step.data_byte == pemf_pkg::CHAR_CR)) begin
                    n_phase = pemf_pkg::PH_AFTER_CR;
                end
            end
            default: begin
                n_phase = pemf_pkg::PH_IDLE;
            end
        endcase
        if (w_eof_first || w_eof_win) begin
            n_phase = pemf_pkg::PH_FIRST;
        end
        if (i_step.last) begin
            n_phase = pemf_pkg::PH_IDLE;
        end
    end

    always_comb begin
        w_skip_set = 1'b0;
        w_skip_val = 2'd0;
        unique case (r_phase)
            pemf_pkg::PH_FIRST: begin
                if (!i_step.lookahead && ((i_step.data_byte == pemf_pkg::CHAR_CR)
                                          || (i_step.data_byte == pemf_pkg::CHAR_LF))) begin
                    w_skip_set = 1'b1;
                    w_skip_val = 2'd1;
                end
            end
            pemf_pkg::PH_AFTER_CR: begin
                if (i_step.data_byte == pemf_pkg::CHAR_LF) begin
                    w_skip_set = 1'b1;
                    w_skip_val = 2'd2;
                end
            end
            default: begin
                w_skip_set = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_pos        = (r_pos == 32'hFFFF_FFFF) ? r_pos : w_end[31:0];
        n_xref_seen  = r_xref_seen;
        n_xref_end   = r_xref_end;
        n_first_seen = r_first_seen;
        n_first_end  = r_first_end;
        n_last_seen  = r_last_seen;
        n_last_end   = r_last_end;
        n_first_skip = r_first_skip;
        n_last_skip  = r_last_skip;

        if (w_skip_set) begin
            if (r_xref_seen) begin
                n_last_skip = w_skip_val;
            end else begin
                n_first_skip = w_skip_val;
            end
        end
        if (i_match.xref_hit && !r_xref_seen) begin
            n_xref_seen = 1'b1;
            n_xref_end  = w_end[31:0];
        end
        if (w_eof_first) begin
            n_first_seen = 1'b1;
            n_first_end  = w_end[31:0];
            n_first_skip = 2'd0;
        end
        if (w_eof_win) begin
            n_last_seen = 1'b1;
            n_last_end  = w_end[31:0];
            n_last_skip = 2'd0;
        end
    end

    always_comb begin
        w_sel_end  = n_xref_seen ? n_last_end  : n_first_end;
        w_sel_skip = n_xref_seen ? n_last_skip : n_first_skip;
        o_result.found = n_xref_seen ? n_last_seen : n_first_seen;
        o_result.end_offset = o_result.found ? (w_sel_end + {30'd0, w_sel_skip}) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.advance && i_step.last)) begin
            r_pos        <= '0;
            r_xref_seen  <= 1'b0;
            r_xref_end   <= '0;
            r_first_seen <= 1'b0;
            r_first_end  <= '0;
            r_last_seen  <= 1'b0;
            r_last_end   <= '0;
            r_first_skip <= '0;
            r_last_skip  <= '0;
            r_phase      <= pemf_pkg::PH_IDLE;
        end else if (i_step.advance) begin
            r_pos        <= n_pos;
            r_xref_seen  <= n_xref_seen;
            r_xref_end   <= n_xref_end;
            r_first_seen <= n_first_seen;
            r_first_end  <= n_first_end;
            r_last_seen  <= n_last_seen;
            r_last_end   <= n_last_end;
            r_first_skip <= n_first_skip;
            r_last_skip  <= n_last_skip;
            r_phase      <= n_phase;
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.advance && i_step.last) |=> (r_pos == 32'd0) && !r_xref_seen)
        else $error("State not cleared after the final word.");
    a_window_needs_xref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_seen |-> r_xref_seen)
        else $error("Windowed end marker recorded without startxref.");
    a_xref_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.advance && !i_step.last && i_match.xref_hit) |=> r_xref_seen)
        else $error("Completed startxref not recorded.");
`endif

endmodule

/* hdl/pdf_end_marker_finder.sv */
// ----------------------------------------------------------------------------
// pdf_end_marker_finder
// Scans a carve region byte by byte and reports where the PDF document ends.
//
//   Channel  Direction  Handshake                  Word
//   input    in         i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   output   out        o_out_valid / i_out_ready  o_out_word (t_out_word)
//   config   in         i_cfg_wr_en                i_cfg_wr_data (search window)
//
// One word is accepted per clock; the marker matchers and position tracking
// complete in the single stage between the input and result registers.
// A result is registered as its final word leaves the input register.
// Reset clears all tracking state and restores the default search window.
// A final word waits in the input register only while a previous result is
// still untaken, and the input is held not ready meanwhile; other words never
// wait.
// ----------------------------------------------------------------------------
module pdf_end_marker_finder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pemf_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pemf_pkg::t_out_word o_out_word,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data
);

    logic                r_in_valid;
    pemf_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    pemf_pkg::t_out_word r_out_word;
    logic [31:0]         r_window;

    logic                w_advance;
    pemf_pkg::t_step     w_step;
    pemf_pkg::t_match    w_match;
    pemf_pkg::t_out_word w_result;

    assign w_advance  = r_in_valid && (!r_in_word.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_comb begin
        w_step.advance   = w_advance;
        w_step.data_byte = r_in_word.data_byte;
        w_step.lookahead = r_in_word.lookahead;
        w_step.last      = r_in_word.last;
    end

    pemf_matcher u_matcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_match (w_match)
    );

    pemf_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_match  (w_match),
        .i_window (r_window),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= pemf_pkg::WINDOW_DEFAULT;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_word.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_word.last) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_word.last) |=> o_out_valid)
        else $error("No result after the final word.");
    a_last_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_word.last && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("Input taken while a final word is blocked.");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("Result changed while waiting to be taken.");
`endif

endmodule

/* tb/sv/tb_pdf_end_marker_finder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pdf_end_marker_finder
// Self-checking testbench for the PDF end marker finder. A short table of
// directed words is followed by random carve regions built from marker text,
// line endings, broken markers, noise and bytes past the region limit. The
// regions run under a sweep of search windows. A predictor tracks the scan and
// each end result is compared with it. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pdf_end_marker_finder;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          PHASE_WORDS    = 120;
    localparam int          PHASE_ENDS     = 5;
    localparam int          NUM_WINDOWS    = 10;
    localparam logic [71:0] XREF_TEXT      = "startxref";
    localparam logic [39:0] EOF_TEXT       = "%%EOF";
    localparam logic [7:0]  CR_BYTE        = 8'h0D;
    localparam logic [7:0]  LF_BYTE        = 8'h0A;

    localparam logic [31:0] WINDOWS [NUM_WINDOWS] = '{
        32'd1, 32'd0, 32'd5, 32'd12, 32'd30, 32'd64,
        32'h8000_0000, 32'hFFFF_FFFF, 32'd7, pemf_pkg::WINDOW_DEFAULT
    };

    typedef struct packed {
        pemf_pkg::t_in_word  word;
        logic                typed;
        pemf_pkg::t_out_word result;
    } t_dir_row;

    localparam int NUM_DIR = 21;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 32'd0}},
        '{'{8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 32'd0}},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"E",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"O",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"F",   1'b0, 1'b0}, 1'b0, '0},
        '{'{CR_BYTE, 1'b0, 1'b0}, 1'b0, '0},
        '{'{LF_BYTE, 1'b1, 1'b1}, 1'b0, '0},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"E",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"O",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"F",   1'b0, 1'b0}, 1'b0, '0},
        '{'{CR_BYTE, 1'b1, 1'b1}, 1'b0, '0},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"%",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"E",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"O",   1'b0, 1'b0}, 1'b0, '0},
        '{'{"F",   1'b0, 1'b0}, 1'b0, '0},
        '{'{CR_BYTE, 1'b0, 1'b1}, 1'b0, '0}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    pemf_pkg::t_in_word  i_in_word     = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    pemf_pkg::t_out_word o_out_word;
    logic                i_cfg_wr_en   = 1'b0;
    logic [31:0]         i_cfg_wr_data = '0;

    bit          quiet         = 1'b0;
    int          cycles        = 0;
    int          mismatches    = 0;
    int          words_sent    = 0;
    int          lookahead_sent = 0;
    int          regions_sent  = 0;
    int          ends_checked  = 0;

    pemf_pkg::t_out_word awaited_ends [$];
    pemf_pkg::t_in_word  region [$];

    // Predicted scan state.
    logic [31:0] window_cfg;
    logic [31:0] scan_pos;
    logic [71:0] recent;
    logic        xref_seen;
    logic [31:0] xref_end;
    logic        first_seen;
    logic [31:0] first_end;
    logic        last_seen;
    logic [31:0] last_end;
    logic [1:0]  first_skip;
    logic [1:0]  last_skip;
    pemf_pkg::t_eol_phase eol_phase;

    pdf_end_marker_finder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void clear_scan();
        scan_pos   = '0;
        recent     = '0;
        xref_seen  = 1'b0;
        xref_end   = '0;
        first_seen = 1'b0;
        first_end  = '0;
        last_seen  = 1'b0;
        last_end   = '0;
        first_skip = '0;
        last_skip  = '0;
        eol_phase  = pemf_pkg::PH_IDLE;
    endfunction

    function automatic void note_skip(input logic [1:0] n);
        if (xref_seen) begin
            last_skip = n;
        end else begin
            first_skip = n;
        end
    endfunction

    function automatic bit predict_end(input pemf_pkg::t_in_word w,
                                       output pemf_pkg::t_out_word res);
        logic [32:0] end_pos;
        end_pos = {1'b0, scan_pos} + 33'd1;
        res = '0;

        case (eol_phase)
            pemf_pkg::PH_FIRST: begin
                eol_phase = pemf_pkg::PH_IDLE;
                if (!w.lookahead) begin
                    if (w.data_byte == CR_BYTE) begin
                        note_skip(2'd1);
                        eol_phase = pemf_pkg::PH_AFTER_CR;
                    end else if (w.data_byte == LF_BYTE) begin
                        note_skip(2'd1);
                    end
                end
            end
            pemf_pkg::PH_AFTER_CR: begin
                eol_phase = pemf_pkg::PH_IDLE;
                if (w.data_byte == LF_BYTE) note_skip(2'd2);
            end
            default: begin
                eol_phase = pemf_pkg::PH_IDLE;
            end
        endcase

        if (w.lookahead) begin
            recent = '0;
        end else begin
            recent = {recent[63:0], w.data_byte};
            if (!xref_seen && recent == XREF_TEXT) begin
                xref_seen = 1'b1;
                xref_end  = end_pos[31:0];
            end
            if (recent[39:0] == EOF_TEXT) begin
                if (!xref_seen) begin
                    if (!first_seen) begin
                        first_seen = 1'b1;
                        first_end  = end_pos[31:0];
                        first_skip = '0;
                        eol_phase  = pemf_pkg::PH_FIRST;
                    end
                end else if (end_pos - 33'd5 >= {1'b0, xref_end} &&
                             end_pos <= {1'b0, xref_end} + {1'b0, window_cfg}) begin
                    last_seen = 1'b1;
                    last_end  = end_pos[31:0];
                    last_skip = '0;
                    eol_phase = pemf_pkg::PH_FIRST;
                end
            end
        end

        if (scan_pos != 32'hFFFF_FFFF) scan_pos = scan_pos + 32'd1;

        if (!w.last) return 1'b0;

        if (xref_seen) begin
            res.found      = last_seen;
            res.end_offset = last_seen ? last_end + {30'd0, last_skip} : 32'd0;
        end else begin
            res.found      = first_seen;
            res.end_offset = first_seen ? first_end + {30'd0, first_skip} : 32'd0;
        end
        clear_scan();
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input pemf_pkg::t_in_word w, input logic typed,
                             input pemf_pkg::t_out_word typed_res);
        pemf_pkg::t_out_word res;
        bit                  produced;
        while (!quiet && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        produced = predict_end(w, res);
        if (produced) awaited_ends.insert(awaited_ends.size(), typed ? typed_res : res);
        words_sent++;
        if (w.lookahead) lookahead_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (awaited_ends.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        wait_for_results();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        window_cfg = value;
    endtask

    function automatic pemf_pkg::t_in_word make_word(input logic [7:0] b, input logic look);
        pemf_pkg::t_in_word w;
        w.data_byte = b;
        w.lookahead = look;
        w.last      = 1'b0;
        return w;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) region.insert(region.size(), make_word(s[i], 1'b0));
    endfunction

    function automatic logic [7:0] pick_byte();
        string marker_chars;
        marker_chars = "startxref%%EOF";
        case ($urandom_range(0, 3))
            0: return CR_BYTE;
            1: return marker_chars[$urandom_range(0, marker_chars.len() - 1)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++) region.insert(region.size(), make_word(pick_byte(), 1'b0));
    endfunction

    function automatic string pick_eol();
        case ($urandom_range(0, 5))
            0, 1: return "\r\n";
            2: return "\r";
            3: return "\n";
            4: return "\n\r";
            default: return "";
        endcase
    endfunction

    function automatic void build_region();
        int n;
        region.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                region.insert(region.size(), make_word(8'($urandom_range(0, 255)),
                                                       $urandom_range(0, 3) == 0));
            end
        end else begin
            if ($urandom_range(0, 2) == 0) add_noise($urandom_range(1, 6));
            if ($urandom_range(0, 2) == 0) begin
                add_text("%%EOF");
                add_text(pick_eol());
            end
            case ($urandom_range(0, 5))
                0: add_text("startxre");
                1: add_text("sstartxref");
                default: add_text("startxref");
            endcase
            n = $urandom_range(1, 6);
            for (int f = 0; f < n; f++) begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        add_text("%%EOF");
                        add_text(pick_eol());
                    end
                    2: begin
                        for (int i = $urandom_range(0, 40); i > 0; i--) add_text("x");
                    end
                    3: add_noise($urandom_range(1, 5));
                    4: begin
                        case ($urandom_range(0, 2))
                            0: add_text("%%EO");
                            1: add_text("%EOF");
                            default: add_text("%%E0F");
                        endcase
                    end
                    5: add_text("startxref");
                    6: add_text("%%%EOF");
                    default: add_text(pick_eol());
                endcase
            end
        end

        case ($urandom_range(0, 5))
            0: begin
                for (int i = $urandom_range(1, 2); i > 0; i--) begin
                    region.insert(region.size(),
                                  make_word($urandom_range(0, 1) ? CR_BYTE : LF_BYTE, 1'b1));
                end
            end
            1: begin
                region.insert(region.size(), make_word(pick_byte(), 1'b1));
                if ($urandom_range(0, 1)) add_text("%%EOF\r\n");
                else add_noise($urandom_range(1, 4));
            end
            default: begin
            end
        endcase

        if (region.size() == 0) add_noise(1);
        region[region.size() - 1].last = 1'b1;
    endfunction

    initial begin
        forever begin
            @(negedge i_clk);
            i_out_ready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        pemf_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_ends.size() == 0) begin
                $error("unexpected result: found %0d end_offset %0d",
                       o_out_word.found, o_out_word.end_offset);
                mismatches++;
            end else begin
                want = awaited_ends.pop_front();
                ends_checked++;
                if (o_out_word.found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_out_word.found);
                    mismatches++;
                end
                if (o_out_word.end_offset !== want.end_offset) begin
                    $error("end_offset: expected %0d, actual %0d",
                           want.end_offset, o_out_word.end_offset);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int phase_words;
        int phase_ends;
        window_cfg = pemf_pkg::WINDOW_DEFAULT;
        clear_scan();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_DIR; r++) begin
            send_word(DIR_ROWS[r].word, DIR_ROWS[r].typed, DIR_ROWS[r].result);
        end

        for (int p = 0; p < NUM_WINDOWS; p++) begin
            write_window(WINDOWS[p]);
            quiet = (p == 3);
            phase_words = 0;
            phase_ends  = 0;
            while (phase_words < PHASE_WORDS || phase_ends < PHASE_ENDS) begin
                build_region();
                foreach (region[i]) send_word(region[i], 1'b0, '0);
                phase_words += region.size();
                phase_ends++;
                regions_sent++;
                if ($urandom_range(0, 7) == 0) wait_for_results();
            end
        end
        quiet = 1'b0;

        wait_for_results();
        repeat (10) @(posedge i_clk);

        $display("Scanned %0d words (%0d past the region limit) in %0d regions.",
                 words_sent, lookahead_sent, regions_sent);
        $display("Checked %0d end results over %0d search window settings.",
                 ends_checked, NUM_WINDOWS);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
